[rtl/bx_pkg.sv]
`default_nettype none

package bx_pkg;

  localparam int MaxSide    = 1024;
  localparam int AddrW      = $clog2(MaxSide);
  localparam int ChanW      = 16;
  localparam int PosW       = 10;
  localparam int SideW      = 11;
  localparam int S2W        = ChanW + 1;
  localparam int S3W        = ChanW + 2;
  localparam int SumW       = ChanW + 4;
  localparam int MulW       = 23;
  localparam int RecipShift = 24;

  localparam logic [MulW-1:0]  Recip3    = MulW'(5592406);
  localparam logic [MulW-1:0]  Recip9    = MulW'(1864136);
  localparam logic [SideW-1:0] SideReset = SideW'(32);

  typedef logic [2:0][ChanW-1:0] pix_t;
  typedef logic [2:0][SumW-1:0]  sums_t;

  typedef struct packed {
    logic [2:0][S3W-1:0] s3;
    logic [2:0][S2W-1:0] s2;
  } col_t;

  typedef enum logic [1:0] {
    DivBy4 = 2'd0,
    DivBy6 = 2'd1,
    DivBy9 = 2'd2
  } div_e;

  function automatic col_t col_sums(pix_t top, pix_t mid, pix_t bot);
    col_t res;
    for (int ch = 0; ch < 3; ch++) begin
      res.s2[ch] = {1'b0, mid[ch]} + {1'b0, bot[ch]};
      res.s3[ch] = {2'b00, top[ch]} + {1'b0, res.s2[ch]};
    end
    return res;
  endfunction

endpackage

`default_nettype wire

[rtl/bx_cell.sv]
`default_nettype none

module bx_cell import bx_pkg::*; (
  input  wire   clk_i,
  input  wire   shift_i,
  input  col_t  col_i,
  input  wire   full_i,
  output col_t  col_o,
  output sums_t term_o
);

  col_t col_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      col_q <= col_i;
    end
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      if (full_i) begin
        term_o[ch] = SumW'(col_q.s3[ch]);
      end else begin
        term_o[ch] = SumW'(col_q.s2[ch]);
      end
    end
  end

  assign col_o = col_q;

endmodule

`default_nettype wire

[rtl/bx_div.sv]
`default_nettype none

module bx_div import bx_pkg::*; (
  input  wire  [SumW-1:0]  sum_i,
  input  div_e             div_i,
  output logic [ChanW-1:0] quot_o
);

  logic [SumW-1:0]      op;
  logic [MulW-1:0]      recip;
  logic [SumW+MulW-1:0] prod;

  always_comb begin
    case (div_i)
      DivBy9: begin
        op    = sum_i;
        recip = Recip9;
      end
      DivBy6: begin
        op    = sum_i >> 1;
        recip = Recip3;
      end
      default: begin
        op    = '0;
        recip = '0;
      end
    endcase
    prod = {{MulW{1'b0}}, op} * {{SumW{1'b0}}, recip};
    if (div_i == DivBy4) begin
      quot_o = sum_i[ChanW+1:2];
    end else begin
      quot_o = prod[RecipShift +: ChanW];
    end
  end

endmodule

`default_nettype wire

[rtl/box_smooth_3x3.sv]
// Channel   Dir  Content
// s_axis    in   source pixel, raster order
// m_axis    out  smoothed pixel with row and column, tlast on final result of a pixel
// cfg       in   image side, write only, restarts the image
//
// One pixel per cycle in the interior of the image while m_axis takes results; a pixel
// at a row end or in the last row gives up to four results, one per output cycle.
// A result passes the line store read at pixel accept, then window shift,
// window sum, and divide into the output register.
// Reset clears control and counters; line stores and window are not cleared.
// A stall on m_axis backs up stage by stage; input is taken while stages free.
`default_nettype none

module box_smooth_3x3 import bx_pkg::*; (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               cfg_we_i,
  input  wire  [SideW-1:0]  cfg_wdata_i,
  input  wire               s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire  [47:0]       s_axis_tdata,   // in_red, in_green, in_blue
  output logic              m_axis_tvalid,
  input  wire               m_axis_tready,
  output logic [71:0]       m_axis_tdata,   // pad, out_red, out_green, out_blue, out_col, out_row
  output logic              m_axis_tlast    // last_in_run
);

  localparam int OutW = 2 * PosW + 3 * ChanW;

  logic [SideW-1:0] side_q;
  logic [PosW-1:0]  side_m1;
  logic [PosW-1:0]  row_q, row_d, col_q, col_d;
  logic [PosW-1:0]  row_cur, col_cur;
  logic [AddrW-1:0] rd_addr, wr_addr;
  logic             s_acc;

  logic             s1_valid_q;
  pix_t             s1_px_q;
  logic [PosW-1:0]  s1_row_q, s1_col_q;
  logic             s1_rend_q, s1_lrow_q;
  pix_t             old_rd_q, new_rd_q;
  logic             s1_adv;

  pix_t             older_mem [MaxSide];
  pix_t             newer_mem [MaxSide];

  col_t             col_in  [3];
  col_t             col_out [3];
  sums_t            term    [3];

  logic             job_valid_q;
  logic [3:0]       job_pend_q;
  logic [PosW-1:0]  job_row_q, job_col_q;
  logic             job_rfull_q, job_cfull_q;
  logic [3:0]       sel, pend_rest;
  logic             sub_last, sub_full, sub_col0;
  logic [PosW-1:0]  sub_row, sub_col;
  sums_t            sub_sum;
  div_e             sub_div;
  logic             job_issue, job_done, job_free;

  logic             sum_valid_q;
  sums_t            sum_q;
  div_e             div_q;
  logic [PosW-1:0]  sum_row_q, sum_col_q;
  logic             sum_last_q;
  logic             sum_free, sum_adv;
  logic [2:0][ChanW-1:0] quot;

  logic             m_valid_q;
  logic [OutW-1:0]  m_data_q;
  logic             m_last_q;
  logic             out_free;

  // ---- side and position counters ----
  always_comb begin
    if (side_q < SideW'(2)) begin
      side_m1 = PosW'(1);
    end else if (side_q > SideW'(MaxSide)) begin
      side_m1 = PosW'(MaxSide - 1);
    end else begin
      side_m1 = PosW'(side_q - SideW'(1));
    end
  end

  always_comb begin
    if (row_q > side_m1 || col_q > side_m1) begin
      row_cur = '0;
      col_cur = '0;
    end else begin
      row_cur = row_q;
      col_cur = col_q;
    end
    row_d = row_cur;
    col_d = col_cur + PosW'(1);
    if (col_cur == side_m1) begin
      col_d = '0;
      row_d = (row_cur == side_m1) ? '0 : row_cur + PosW'(1);
    end
  end

  assign s_acc   = s_axis_tvalid & s_axis_tready;
  assign rd_addr = AddrW'(col_cur);
  assign wr_addr = AddrW'(s1_col_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= SideReset;
      row_q  <= '0;
      col_q  <= '0;
    end else if (cfg_we_i) begin
      side_q <= cfg_wdata_i;
      row_q  <= '0;
      col_q  <= '0;
    end else if (s_acc) begin
      row_q  <= row_d;
      col_q  <= col_d;
    end
  end

  // ---- line store read stage ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      s1_px_q   <= s_axis_tdata;
      s1_row_q  <= row_cur;
      s1_col_q  <= col_cur;
      s1_rend_q <= (col_cur == side_m1);
      s1_lrow_q <= (row_cur == side_m1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      old_rd_q <= older_mem[rd_addr];
    end
    if (s1_adv) begin
      older_mem[wr_addr] <= new_rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      new_rd_q <= newer_mem[rd_addr];
    end
    if (s1_adv) begin
      newer_mem[wr_addr] <= s1_px_q;
    end
  end

  // ---- window: three column cells, newest on the right ----
  assign col_in[2] = col_sums(old_rd_q, new_rd_q, s1_px_q);
  assign col_in[1] = col_out[2];
  assign col_in[0] = col_out[1];

  for (genvar i = 0; i < 3; i++) begin : g_cell
    bx_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (s1_adv),
      .col_i   (col_in[i]),
      .full_i  (sub_full),
      .col_o   (col_out[i]),
      .term_o  (term[i])
    );
  end

  // ---- result sequencer over the window ----
  always_comb begin
    sel       = job_pend_q & (~job_pend_q + 4'd1);
    pend_rest = job_pend_q & ~sel;
    sub_last  = (pend_rest == 4'd0);
    sub_full  = (sel[0] | sel[1]) & job_rfull_q;
    sub_col0  = (sel[0] | sel[2]) & job_cfull_q;
    sub_row   = (sel[2] | sel[3]) ? job_row_q : job_row_q - PosW'(1);
    sub_col   = (sel[1] | sel[3]) ? job_col_q : job_col_q - PosW'(1);
    for (int ch = 0; ch < 3; ch++) begin
      sub_sum[ch] = (sub_col0 ? term[0][ch] : '0) + term[1][ch] + term[2][ch];
    end
    if (sub_full && sub_col0) begin
      sub_div = DivBy9;
    end else if (sub_full || sub_col0) begin
      sub_div = DivBy6;
    end else begin
      sub_div = DivBy4;
    end
  end

  assign out_free  = !m_valid_q || m_axis_tready;
  assign sum_adv   = sum_valid_q && out_free;
  assign sum_free  = !sum_valid_q || out_free;
  assign job_issue = job_valid_q && sum_free;
  assign job_done  = job_issue && sub_last;
  assign job_free  = !job_valid_q || job_done;
  assign s1_adv    = s1_valid_q && job_free;
  assign s_axis_tready = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
      job_pend_q  <= '0;
    end else if (s1_adv) begin
      job_valid_q <= (s1_row_q != '0) && (s1_col_q != '0);
      job_pend_q  <= {s1_rend_q & s1_lrow_q, s1_lrow_q, s1_rend_q, 1'b1};
    end else if (job_issue) begin
      job_pend_q <= pend_rest;
      if (sub_last) begin
        job_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      job_row_q   <= s1_row_q;
      job_col_q   <= s1_col_q;
      job_rfull_q <= (s1_row_q >= PosW'(2));
      job_cfull_q <= (s1_col_q >= PosW'(2));
    end
  end

  // ---- sum stage ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_valid_q <= 1'b0;
    end else if (job_issue) begin
      sum_valid_q <= 1'b1;
    end else if (sum_adv) begin
      sum_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_issue) begin
      sum_q      <= sub_sum;
      div_q      <= sub_div;
      sum_row_q  <= sub_row;
      sum_col_q  <= sub_col;
      sum_last_q <= sub_last;
    end
  end

  // ---- divide and output register ----
  for (genvar ch = 0; ch < 3; ch++) begin : g_div
    bx_div u_div (
      .sum_i  (sum_q[ch]),
      .div_i  (div_q),
      .quot_o (quot[ch])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (sum_adv) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sum_adv) begin
      m_data_q <= {quot[2], quot[1], quot[0], sum_col_q, sum_row_q};
      m_last_q <= sum_last_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{(72 - OutW){1'b0}}, m_data_q};
  assign m_axis_tlast  = m_last_q;

  // ---- checks ----
  a_job_has_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_q |-> (job_pend_q != 4'd0))
    else $error("window job valid with no pending result");

  a_div9_interior: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sum_valid_q && div_q == DivBy9) |-> (sum_row_q != '0 && sum_col_q != '0))
    else $error("full 3x3 mean on a border pixel");

  a_div4_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sum_valid_q && div_q == DivBy4) |->
      (sum_q[0][SumW-1:S3W] == '0 && sum_q[1][SumW-1:S3W] == '0 &&
       sum_q[2][SumW-1:S3W] == '0))
    else $error("corner sum exceeds four pixels");

  a_shift_only_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |-> (!job_valid_q || job_done))
    else $error("window shifted under a pending job");

endmodule

`default_nettype wire
